### hdl/fdb_pkg.sv
// ============================================================================
// fdb_pkg
// Shared types and constants of the frame downscaler and binarizer.
// ============================================================================
package fdb_pkg;

    // Display geometry: 128 x 64 pixels, read out as 64-pixel half-rows.
    localparam int OUT_WIDTH_LOG2  = 7;
    localparam int OUT_HEIGHT_LOG2 = 6;
    localparam int WORD_BITS       = 64;
    localparam int WIDX_W          = 7;

    // Frame mean accumulator and threshold arithmetic.
    localparam int SUM_W         = 22;
    localparam int PIX_W         = 8;
    localparam int THRESH_OFFSET = 10;
    localparam int PIX_MAX       = 255;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;
    localparam int DIM_W      = 9;

    localparam logic [CFG_IDX_W-1:0] REG_ADAPTIVE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIXED_THR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOOST     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 3'd4;

    localparam logic             RST_ADAPTIVE  = 1'b1;
    localparam logic [PIX_W-1:0] RST_FIXED_THR = 8'd128;
    localparam logic [PIX_W-1:0] RST_BOOST     = 8'd30;
    localparam logic [DIM_W-1:0] RST_WIDTH     = 9'd160;
    localparam logic [DIM_W-1:0] RST_HEIGHT    = 9'd120;

    // Operation codes carried in the input tuser.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Controller to datapath commands.
    typedef struct packed {
        logic load_en;      // store the pixel of the accepted transfer
        logic req_capture;  // latch the word index of an accepted read
        logic prep1;        // source row, sample count, column accumulator
        logic prep2;        // row base address, divider start
        logic div_step;     // one restoring-division step
        logic thr_latch;    // settle the threshold for this word
        logic issue;        // read one source pixel from the frame store
        logic shift;        // compare the returned pixel, shift in its bit
        logic out_load;     // move the finished word to the output register
    } t_cmd;

endpackage

### hdl/fdb_ram.sv
// ============================================================================
// fdb_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
module fdb_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/fdb_ctrl.sv
// ============================================================================
// fdb_ctrl
// Sequencer: stream handshakes, read-word phases and the output register flag.
// ============================================================================
module fdb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_op,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output fdb_pkg::t_cmd o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_PREP1 = 8'b0000_0010,
        S_PREP2 = 8'b0000_0100,
        S_DIV   = 8'b0000_1000,
        S_THR   = 8'b0001_0000,
        S_GATH  = 8'b0010_0000,
        S_DRAIN = 8'b0100_0000,
        S_FIN   = 8'b1000_0000
    } t_state;

    localparam int CNT_W = $clog2(fdb_pkg::WORD_BITS);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(fdb_pkg::SUM_W - 1);
    localparam logic [CNT_W-1:0] WORD_LAST = CNT_W'(fdb_pkg::WORD_BITS - 1);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_issue_d, n_issue_d;
    logic             r_out_valid, n_out_valid;
    logic             accept;
    logic             out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_issue_d   = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in_op == fdb_pkg::OP_READ) begin
                        o_cmd.req_capture = 1'b1;
                        n_state           = S_PREP1;
                    end else begin
                        o_cmd.load_en = 1'b1;
                    end
                end
            end
            S_PREP1: begin
                o_cmd.prep1 = 1'b1;
                n_state     = S_PREP2;
            end
            S_PREP2: begin
                o_cmd.prep2 = 1'b1;
                n_cnt       = '0;
                n_state     = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_THR;
                end
            end
            S_THR: begin
                o_cmd.thr_latch = 1'b1;
                n_cnt           = '0;
                n_state         = S_GATH;
            end
            S_GATH: begin
                o_cmd.issue = 1'b1;
                o_cmd.shift = r_issue_d;
                n_issue_d   = 1'b1;
                n_cnt       = r_cnt + 1'b1;
                if (r_cnt == WORD_LAST) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                o_cmd.shift = r_issue_d;
                n_state     = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_issue_d   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_issue_d   <= n_issue_d;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### hdl/fdb_dpath.sv
// ============================================================================
// fdb_dpath
// Datapath: configuration registers, load position and frame sum, threshold
// divider, source address generation, pixel compare and the result register.
// ============================================================================
module fdb_dpath #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  fdb_pkg::t_cmd                          i_cmd,
    // configuration writes
    input  logic                                   i_cfg_we,
    input  logic [fdb_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [fdb_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    // input item fields
    input  logic                                   i_first,
    input  logic [fdb_pkg::PIX_W-1:0]              i_pixel,
    input  logic [fdb_pkg::WIDX_W-1:0]             i_word_index,
    // frame store ports
    output logic                                   o_we,
    output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] o_waddr,
    output logic [fdb_pkg::PIX_W-1:0]              o_wdata,
    output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] o_raddr,
    input  logic [fdb_pkg::PIX_W-1:0]              i_rdata,
    // result
    output logic [fdb_pkg::WORD_BITS-1:0]          o_bits,
    output logic [fdb_pkg::PIX_W-1:0]              o_threshold
);

    localparam int W_W   = $clog2(MAX_WIDTH + 1);
    localparam int H_W   = $clog2(MAX_HEIGHT + 1);
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int A_W   = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int SMP_W = W_W + H_W;
    localparam int ACC_W = fdb_pkg::OUT_WIDTH_LOG2 + W_W;
    localparam int Y_W   = fdb_pkg::WIDX_W - 1;
    localparam int SUM_W = fdb_pkg::SUM_W;
    localparam int PIX_W = fdb_pkg::PIX_W;

    // ---------------- configuration registers ----------------
    logic                           r_adaptive;
    logic [PIX_W-1:0]               r_fixed_thr;
    logic [PIX_W-1:0]               r_boost;
    logic [fdb_pkg::DIM_W-1:0]      r_cfg_width;
    logic [fdb_pkg::DIM_W-1:0]      r_cfg_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adaptive   <= fdb_pkg::RST_ADAPTIVE;
            r_fixed_thr  <= fdb_pkg::RST_FIXED_THR;
            r_boost      <= fdb_pkg::RST_BOOST;
            r_cfg_width  <= fdb_pkg::RST_WIDTH;
            r_cfg_height <= fdb_pkg::RST_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                fdb_pkg::REG_ADAPTIVE:  r_adaptive   <= i_cfg_data[0];
                fdb_pkg::REG_FIXED_THR: r_fixed_thr  <= i_cfg_data[PIX_W-1:0];
                fdb_pkg::REG_BOOST:     r_boost      <= i_cfg_data[PIX_W-1:0];
                fdb_pkg::REG_WIDTH:     r_cfg_width  <= i_cfg_data;
                fdb_pkg::REG_HEIGHT:    r_cfg_height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Effective dimensions: zero acts as one, oversize acts as the maximum.
    logic [W_W-1:0] w;
    logic [H_W-1:0] h;

    always_comb begin
        if (r_cfg_width == '0) begin
            w = W_W'(1);
        end else if (int'(r_cfg_width) > MAX_WIDTH) begin
            w = W_W'(MAX_WIDTH);
        end else begin
            w = W_W'(r_cfg_width);
        end
        if (r_cfg_height == '0) begin
            h = H_W'(1);
        end else if (int'(r_cfg_height) > MAX_HEIGHT) begin
            h = H_W'(MAX_HEIGHT);
        end else begin
            h = H_W'(r_cfg_height);
        end
    end

    // ---------------- frame loading ----------------
    logic [COL_W-1:0] r_col, n_col;
    logic [H_W-1:0]   r_row, n_row;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [COL_W-1:0] col_e;
    logic [H_W-1:0]   row_e;
    logic [SUM_W-1:0] sum_e;
    logic             in_frame;
    logic             col_ok;
    logic [W_W:0]     col_inc;
    logic [H_W+W_W-1:0] load_addr;

    always_comb begin
        col_e     = i_first ? '0 : r_col;
        row_e     = i_first ? '0 : r_row;
        sum_e     = i_first ? '0 : r_sum;
        in_frame  = (row_e < h);
        col_ok    = (W_W'(col_e) < w);
        col_inc   = {1'b0, W_W'(col_e)} + 1'b1;
        load_addr = (H_W+W_W)'(row_e * w) + (H_W+W_W)'(col_e);
        n_col     = col_e;
        n_row     = row_e;
        n_sum     = sum_e;
        if (in_frame) begin
            if (col_ok && !row_e[0] && !col_e[0]) begin
                n_sum = sum_e + SUM_W'(i_pixel);
            end
            if (col_inc >= {1'b0, w}) begin
                n_col = '0;
                n_row = row_e + 1'b1;
            end else begin
                n_col = col_inc[COL_W-1:0];
            end
        end
    end

    assign o_we    = i_cmd.load_en && in_frame && col_ok;
    assign o_waddr = load_addr[A_W-1:0];
    assign o_wdata = i_pixel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_sum <= '0;
        end else if (i_cmd.load_en) begin
            r_col <= n_col;
            r_row <= n_row;
            r_sum <= n_sum;
        end
    end

    // ---------------- read word setup ----------------
    logic [fdb_pkg::WIDX_W-1:0] r_widx;
    logic [H_W-1:0]             r_sy;
    logic [SMP_W-1:0]           r_samples;
    logic [ACC_W-1:0]           r_acc;
    logic [A_W-1:0]             r_base;
    logic [Y_W+H_W-1:0]         sy_prod;
    logic [W_W-1:0]             half_w;
    logic [H_W-1:0]             half_h;
    logic [W_W:0]               w_inc;
    logic [H_W:0]               h_inc;
    logic [H_W+W_W-1:0]         base_prod;

    assign sy_prod   = (Y_W+H_W)'(r_widx[fdb_pkg::WIDX_W-1:1] * h);
    assign w_inc     = {1'b0, w} + 1'b1;
    assign h_inc     = {1'b0, h} + 1'b1;
    assign half_w    = w_inc[W_W:1];
    assign half_h    = h_inc[H_W:1];
    assign base_prod = (H_W+W_W)'(r_sy * w);

    // ---------------- threshold divider ----------------
    logic [SMP_W-1:0] r_rem;
    logic [SUM_W-1:0] r_quo;
    logic [SMP_W:0]   trial;
    logic             q_bit;
    logic [SUM_W:0]   q_plus;
    logic [PIX_W-1:0] thr_adapt;
    logic [PIX_W-1:0] r_thr;

    assign trial  = {r_rem, r_quo[SUM_W-1]};
    assign q_bit  = (trial >= {1'b0, r_samples});
    assign q_plus = {1'b0, r_quo} + (SUM_W+1)'(fdb_pkg::THRESH_OFFSET);
    assign thr_adapt = (q_plus > (SUM_W+1)'(fdb_pkg::PIX_MAX)) ?
                       PIX_W'(fdb_pkg::PIX_MAX) : q_plus[PIX_W-1:0];

    // ---------------- pixel compare ----------------
    logic [PIX_W:0]               boosted;
    logic [PIX_W-1:0]             pix_sat;
    logic                         dark;
    logic [fdb_pkg::WORD_BITS-1:0] r_word;
    logic [ACC_W-1:0]             sx_full;

    assign boosted = {1'b0, i_rdata} + {1'b0, r_boost};
    assign pix_sat = boosted[PIX_W] ? PIX_W'(fdb_pkg::PIX_MAX) : boosted[PIX_W-1:0];
    assign dark    = (pix_sat < r_thr);
    assign sx_full = r_acc >> fdb_pkg::OUT_WIDTH_LOG2;
    assign o_raddr = r_base + A_W'(sx_full);

    logic [fdb_pkg::WORD_BITS-1:0] r_out_bits;
    logic [PIX_W-1:0]              r_out_thr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.req_capture) begin
            r_widx <= i_word_index;
        end
        if (i_cmd.prep1) begin
            r_sy      <= sy_prod[Y_W+H_W-1:fdb_pkg::OUT_HEIGHT_LOG2];
            r_samples <= SMP_W'(half_w * half_h);
            r_acc     <= r_widx[0] ? (ACC_W'(w) << (fdb_pkg::WIDX_W - 1)) : '0;
        end
        if (i_cmd.prep2) begin
            r_base <= base_prod[A_W-1:0];
            r_rem  <= '0;
            r_quo  <= r_sum;
        end
        if (i_cmd.div_step) begin
            r_rem <= q_bit ? SMP_W'(trial - {1'b0, r_samples}) : trial[SMP_W-1:0];
            r_quo <= {r_quo[SUM_W-2:0], q_bit};
        end
        if (i_cmd.thr_latch) begin
            r_thr <= r_adaptive ? thr_adapt : r_fixed_thr;
        end
        if (i_cmd.issue) begin
            r_acc <= r_acc + ACC_W'(w);
        end
        if (i_cmd.shift) begin
            r_word <= {dark, r_word[fdb_pkg::WORD_BITS-1:1]};
        end
        if (i_cmd.out_load) begin
            r_out_bits <= r_word;
            r_out_thr  <= r_thr;
        end
    end

    assign o_bits      = r_out_bits;
    assign o_threshold = r_out_thr;

endmodule

### hdl/frame_downscale_binarize.sv
// ============================================================================
// frame_downscale_binarize
// Grayscale frame store with nearest-neighbor downscale to a 128 x 64
// monochrome display and mean or fixed threshold binarization.
// ============================================================================
// A load transfer (tuser operation bit low) writes one pixel into the frame
// store in raster order unless it falls outside the frame; loads stream at
// one per clock while no read is in progress. A read transfer (operation
// bit high) returns one 64-pixel half-row of the display: the block first
// divides the frame's even-row, even-column sum by the sample count with a
// one-bit-per-cycle divider, then fetches the 64 source pixels from the frame
// store through its single read port, one per cycle. The input is not ready
// again until setup, division, fetch and drain are done and the word has
// moved to the output register, a move that waits while an earlier word sits
// unaccepted there. The finished word waits in that output register, so the
// next item is taken while a result is still pending.
// The frame store holds MAX_WIDTH * MAX_HEIGHT bytes and is not cleared;
// reading a location that was never loaded returns whatever it holds.
// ============================================================================
module frame_downscale_binarize #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [7:0] pixel, [14:8] word_index, [15] zero
    input  logic [1:0]  s_axis_tuser,  // [0] operation, [1] first_of_frame
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata, // [63:0] bits, [71:64] threshold_used
    // Configuration write channel.
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [fdb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [fdb_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int A_W   = $clog2(DEPTH);

    fdb_pkg::t_cmd                   cmd;
    logic                            ram_we;
    logic [A_W-1:0]                  ram_waddr;
    logic [A_W-1:0]                  ram_raddr;
    logic [fdb_pkg::PIX_W-1:0]       ram_wdata;
    logic [fdb_pkg::PIX_W-1:0]       ram_rdata;
    logic [fdb_pkg::WORD_BITS-1:0]   out_bits;
    logic [fdb_pkg::PIX_W-1:0]       out_thr;

    // Configuration writes are taken in any cycle and take effect at once.
    // Write the registers only while no item is in flight.
    assign o_cfg_ready = 1'b1;

    // The controller owns the stream handshakes and sequences each read word.
    fdb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_op     (s_axis_tuser[0]),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    // The datapath holds the configuration, the load position and sum, the
    // divider, address generation and the compare-and-shift word builder.
    fdb_dpath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_cfg_we     (i_cfg_valid && o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_first      (s_axis_tuser[1]),
        .i_pixel      (s_axis_tdata[7:0]),
        .i_word_index (s_axis_tdata[14:8]),
        .o_we         (ram_we),
        .o_waddr      (ram_waddr),
        .o_wdata      (ram_wdata),
        .o_raddr      (ram_raddr),
        .i_rdata      (ram_rdata),
        .o_bits       (out_bits),
        .o_threshold  (out_thr)
    );

    // Frame store, addressed as row * width + column.
    fdb_ram #(
        .DATA_W (fdb_pkg::PIX_W),
        .DEPTH  (DEPTH)
    ) u_frame_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (cmd.issue),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign m_axis_tdata = {out_thr, out_bits};

endmodule

### dv/frame_downscale_binarize_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// frame_downscale_binarize_tb
// Self-checking bench for the frame downscaler and binarizer. A behavioral
// copy of the frame store, the sample sum and the load position predicts
// every display word. Small frames are loaded and then read back under
// changing register settings, with random gaps on both streams.
// ============================================================================
module frame_downscale_binarize_tb;

    // Block geometry. The display size follows from the package.
    localparam int MAX_W  = 256;
    localparam int MAX_H  = 256;
    localparam int DISP_W = 1 << fdb_pkg::OUT_WIDTH_LOG2;
    localparam int DISP_H = 1 << fdb_pkg::OUT_HEIGHT_LOG2;

    // Pause length, rounded up from the time a read keeps the input busy.
    localparam int READ_LATENCY   = 100;
    // Length of the long receiver hold-off in the back-pressure test.
    localparam int HOLD_CYCLES    = 400;
    // Cycles without any transfer before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_REPORTS    = 10;

    // One display word as the result stream carries it.
    typedef struct packed {
        logic [fdb_pkg::WORD_BITS-1:0] bits;
        logic [fdb_pkg::PIX_W-1:0]     thr;
    } t_disp_word;

    // ------------------------------------------------------------------------
    // Clock, reset and block ports. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [15:0]                    s_axis_tdata  = '0;  // [7:0] pixel, [14:8] word_index, [15] zero
    logic [1:0]                     s_axis_tuser  = '0;  // [0] operation, [1] first_of_frame
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [71:0]                    m_axis_tdata;        // [63:0] bits, [71:64] threshold_used
    logic                           i_cfg_valid   = 1'b0;
    logic                           o_cfg_ready;
    logic [fdb_pkg::CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [fdb_pkg::CFG_DATA_W-1:0] i_cfg_data    = '0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    frame_downscale_binarize #(
        .MAX_WIDTH (MAX_W),
        .MAX_HEIGHT(MAX_H)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // Shadow of the block's registers and state, kept by the bench.
    // ------------------------------------------------------------------------
    logic                      cfg_adaptive  = fdb_pkg::RST_ADAPTIVE;
    logic [fdb_pkg::PIX_W-1:0] cfg_fixed_thr = fdb_pkg::RST_FIXED_THR;
    logic [fdb_pkg::PIX_W-1:0] cfg_boost     = fdb_pkg::RST_BOOST;
    logic [fdb_pkg::DIM_W-1:0] cfg_width     = fdb_pkg::RST_WIDTH;
    logic [fdb_pkg::DIM_W-1:0] cfg_height    = fdb_pkg::RST_HEIGHT;

    // The frame store is not cleared, so the bench tracks which entries hold
    // a loaded pixel and never asks for a word that touches any other entry.
    logic [fdb_pkg::PIX_W-1:0] frame_mem [MAX_W*MAX_H];
    bit                        frame_mem_loaded [MAX_W*MAX_H];
    logic [fdb_pkg::SUM_W-1:0] sample_sum = '0;
    int unsigned               load_col   = 0;
    int unsigned               load_row   = 0;

    t_disp_word  expected_words[$];
    int unsigned mismatch_count = 0;
    int unsigned kept_items     = 0;
    int unsigned stuck_cycles   = 0;

    // Idle controls, in percent of cycles, and the long hold-off request.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    bit          hold_request   = 1'b0;
    int unsigned hold_left      = 0;

    // ------------------------------------------------------------------------
    // Prediction.
    // ------------------------------------------------------------------------

    // A width or height of zero behaves as one; anything above the store
    // limit behaves as the limit.
    function automatic int unsigned active_dim(input logic [fdb_pkg::DIM_W-1:0] v,
                                               input int unsigned maxv);
        if (v == '0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    // Applies one pixel transfer to the shadow state. Returns 1 when the
    // pixel lands in the store, 0 when the block drops it.
    function automatic bit store_pixel(input logic first,
                                       input logic [fdb_pkg::PIX_W-1:0] pix);
        int unsigned w, h, addr;
        bit kept;
        w    = active_dim(cfg_width, MAX_W);
        h    = active_dim(cfg_height, MAX_H);
        kept = 1'b0;
        if (first) begin
            load_col   = 0;
            load_row   = 0;
            sample_sum = '0;
        end
        // Once the frame is full, the position stays put.
        if (load_row >= h) return 1'b0;
        // A column past the width happens only after the width shrank mid-frame;
        // the pixel is lost but the position still wraps to the next row.
        if (load_col < w) begin
            addr = load_row * w + load_col;
            frame_mem[addr]        = pix;
            frame_mem_loaded[addr] = 1'b1;
            kept = 1'b1;
            if ((load_row % 2) == 0 && (load_col % 2) == 0)
                sample_sum = sample_sum + pix;  // wraps at the accumulator width
        end
        if (load_col + 1 >= w) begin
            load_col = 0;
            load_row++;
        end else begin
            load_col++;
        end
        return kept;
    endfunction

    // Works out the display word for a word index. Returns 0 if any source
    // pixel it needs was never loaded.
    function automatic bit predict_word(input logic [fdb_pkg::WIDX_W-1:0] widx,
                                        output t_disp_word res);
        int unsigned w, h, y, sy, x, sx, addr, p, samples, mean;
        bit loaded;
        w      = active_dim(cfg_width, MAX_W);
        h      = active_dim(cfg_height, MAX_H);
        loaded = 1'b1;
        if (cfg_adaptive) begin
            samples = ((w + 1) / 2) * ((h + 1) / 2);
            mean    = sample_sum / samples + fdb_pkg::THRESH_OFFSET;
            if (mean > fdb_pkg::PIX_MAX) mean = fdb_pkg::PIX_MAX;
            res.thr = mean[fdb_pkg::PIX_W-1:0];
        end else begin
            res.thr = cfg_fixed_thr;
        end
        res.bits = '0;
        y = widx / 2;
        if (y < DISP_H) begin
            sy = y * h / DISP_H;
            for (int i = 0; i < fdb_pkg::WORD_BITS; i++) begin
                x = (widx % 2) * fdb_pkg::WORD_BITS + i;
                if (x < DISP_W) begin
                    sx   = x * w / DISP_W;
                    addr = sy * w + sx;
                    if (!frame_mem_loaded[addr]) loaded = 1'b0;
                    p = frame_mem[addr];
                    p = p + cfg_boost;
                    if (p > fdb_pkg::PIX_MAX) p = fdb_pkg::PIX_MAX;
                    if (p < res.thr) res.bits[i] = 1'b1;
                end
            end
        end
        return loaded;
    endfunction

    // ------------------------------------------------------------------------
    // Drivers.
    // ------------------------------------------------------------------------

    // Offers one item and waits for its transfer. tvalid is only lowered while
    // idling, so back-to-back items keep it high with one assignment per edge.
    task automatic send_item(input logic op, input logic first,
                             input logic [fdb_pkg::PIX_W-1:0] pix,
                             input logic [fdb_pkg::WIDX_W-1:0] widx);
        t_disp_word word;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, widx, pix};
        s_axis_tuser  <= {first, op};
        do @(posedge i_clk); while (!s_axis_tready);
        if (op == fdb_pkg::OP_LOAD) begin
            if (store_pixel(first, pix)) kept_items++;
        end else begin
            void'(predict_word(widx, word));
            expected_words.push_back(word);
            kept_items++;
        end
    endtask

    task automatic load_pixel(input logic first, input logic [fdb_pkg::PIX_W-1:0] pix);
        send_item(fdb_pkg::OP_LOAD, first, pix, fdb_pkg::WIDX_W'($urandom_range(127)));
    endtask

    // Requests a word only when every pixel behind it has been loaded.
    task automatic request_word(input logic [fdb_pkg::WIDX_W-1:0] widx);
        t_disp_word word;
        if (predict_word(widx, word))
            send_item(fdb_pkg::OP_READ, 1'($urandom_range(1)),
                      fdb_pkg::PIX_W'($urandom_range(255)), widx);
    endtask

    // Waits until the block is idle: every result back, and enough cycles for
    // any load still in flight to finish.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (READ_LATENCY) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [fdb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [fdb_pkg::CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            fdb_pkg::REG_ADAPTIVE:  cfg_adaptive  = val[0];
            fdb_pkg::REG_FIXED_THR: cfg_fixed_thr = val[fdb_pkg::PIX_W-1:0];
            fdb_pkg::REG_BOOST:     cfg_boost     = val[fdb_pkg::PIX_W-1:0];
            fdb_pkg::REG_WIDTH:     cfg_width     = val[fdb_pkg::DIM_W-1:0];
            fdb_pkg::REG_HEIGHT:    cfg_height    = val[fdb_pkg::DIM_W-1:0];
            default: ;
        endcase
    endtask

    // Writes all five registers; only called while the block is idle.
    task automatic set_config(input logic adapt, input logic [fdb_pkg::PIX_W-1:0] thr,
                              input logic [fdb_pkg::PIX_W-1:0] boost,
                              input logic [fdb_pkg::DIM_W-1:0] w,
                              input logic [fdb_pkg::DIM_W-1:0] h);
        write_reg(fdb_pkg::REG_ADAPTIVE,  {8'd0, adapt});
        write_reg(fdb_pkg::REG_FIXED_THR, {1'b0, thr});
        write_reg(fdb_pkg::REG_BOOST,     {1'b0, boost});
        write_reg(fdb_pkg::REG_WIDTH,     w);
        write_reg(fdb_pkg::REG_HEIGHT,    h);
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off on request.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: each result transfer against the oldest expected word.
    // ------------------------------------------------------------------------
    task automatic flag_mismatch(input string what,
                                 input logic [fdb_pkg::WORD_BITS-1:0] want,
                                 input logic [fdb_pkg::WORD_BITS-1:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
    endtask

    always @(posedge i_clk) begin : check_results
        t_disp_word want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_words.size() == 0) begin
                flag_mismatch("unrequested word", '0,
                              m_axis_tdata[fdb_pkg::WORD_BITS-1:0]);
            end else begin
                want = expected_words.pop_front();
                if (m_axis_tdata[fdb_pkg::WORD_BITS-1:0] !== want.bits)
                    flag_mismatch("display bits", want.bits,
                                  m_axis_tdata[fdb_pkg::WORD_BITS-1:0]);
                if (m_axis_tdata[fdb_pkg::WORD_BITS+fdb_pkg::PIX_W-1:fdb_pkg::WORD_BITS]
                        !== want.thr)
                    flag_mismatch("threshold", {56'd0, want.thr},
                                  {56'd0, m_axis_tdata[fdb_pkg::WORD_BITS+fdb_pkg::PIX_W-1:
                                                       fdb_pkg::WORD_BITS]});
            end
        end
    end

    // Watchdog: any transfer on any channel counts as progress.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles == WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // A 4 x 3 frame with extreme pixel values, one load past the end of the
    // frame (dropped), and reads of the first, last and a middle word.
    task automatic test_tiny_frame();
        logic [fdb_pkg::PIX_W-1:0] pix [12] = '{8'd0, 8'd255, 8'd128, 8'd127, 8'd64,
                                                8'd200, 8'd10, 8'd250, 8'd3, 8'd130,
                                                8'd90, 8'd255};
        settle();
        set_config(1'b0, 8'd128, 8'd0, 9'd4, 9'd3);
        for (int k = 0; k < 12; k++) load_pixel(k == 0, pix[k]);
        load_pixel(1'b0, 8'd17);
        request_word(7'd0);
        request_word(7'd127);
        request_word(7'd64);
    endtask

    // Same frame under the fixed threshold and boost extremes.
    task automatic test_threshold_extremes();
        settle();
        set_config(1'b0, 8'd0, 8'd255, 9'd4, 9'd3);
        request_word(7'd10);
        settle();
        set_config(1'b0, 8'd255, 8'd0, 9'd4, 9'd3);
        request_word(7'd11);
        settle();
        set_config(1'b0, 8'd255, 8'd255, 9'd4, 9'd3);
        request_word(7'd100);
    endtask

    // A bright single sample pushes the mean plus offset past 255, so the
    // adaptive threshold saturates.
    task automatic test_adaptive_saturation();
        settle();
        set_config(1'b1, 8'd0, 8'd0, 9'd2, 9'd2);
        load_pixel(1'b1, 8'd255);
        load_pixel(1'b0, 8'd254);
        load_pixel(1'b0, 8'd0);
        load_pixel(1'b0, 8'd128);
        request_word(7'd1);
        request_word(7'd126);
    endtask

    // Zero sizes act as one; oversized ones act as the store limit. Only the
    // part of each oversized frame that the requested words need is loaded.
    task automatic test_dimension_clamp();
        settle();
        set_config(1'b1, 8'd128, 8'd30, 9'd0, 9'd0);
        load_pixel(1'b1, 8'd77);
        load_pixel(1'b0, 8'd200);
        request_word(7'd126);
        settle();
        set_config(1'b1, 8'd128, 8'd30, 9'd511, 9'd1);
        for (int k = 0; k < 128; k++)
            load_pixel(k == 0, fdb_pkg::PIX_W'($urandom_range(255)));
        request_word(7'd0);
        request_word(7'd126);
        settle();
        set_config(1'b0, 8'd100, 8'd30, 9'd1, 9'd511);
        for (int k = 0; k < 32; k++)
            load_pixel(k == 0, fdb_pkg::PIX_W'($urandom_range(255)));
        request_word(7'd1);
        request_word(7'd14);
    endtask

    // The width shrinks while the load position sits past the new width: the
    // next pixel is dropped and loading resumes at the start of the next row.
    task automatic test_width_shrink();
        settle();
        set_config(1'b1, 8'd128, 8'd30, 9'd8, 9'd2);
        for (int k = 0; k < 6; k++) load_pixel(k == 0, fdb_pkg::PIX_W'($urandom_range(255)));
        settle();
        set_config(1'b1, 8'd128, 8'd30, 9'd4, 9'd2);
        load_pixel(1'b0, 8'd99);
        for (int k = 0; k < 4; k++) load_pixel(1'b0, fdb_pkg::PIX_W'($urandom_range(255)));
        request_word(7'd0);
        request_word(7'd127);
    endtask

    // A second start of frame midway restarts both the position and the sum.
    task automatic test_frame_restart();
        settle();
        set_config(1'b1, 8'd128, 8'd20, 9'd3, 9'd3);
        for (int k = 0; k < 5; k++) load_pixel(k == 0, 8'd250);
        for (int k = 0; k < 9; k++) load_pixel(k == 0, fdb_pkg::PIX_W'($urandom_range(255)));
        request_word(7'd2);
        request_word(7'd125);
    endtask

    // The receiver holds off for a long stretch while reads keep coming, so
    // the output register fills and the block stalls its input.
    task automatic test_output_backpressure();
        settle();
        set_config(1'b0, 8'd140, 8'd10, 9'd4, 9'd4);
        for (int k = 0; k < 16; k++)
            load_pixel(k == 0, fdb_pkg::PIX_W'($urandom_range(255)));
        hold_request = 1'b1;
        for (int k = 0; k < 6; k++) request_word(fdb_pkg::WIDX_W'($urandom_range(127)));
    endtask

    // Threshold and boost values with their extremes favored.
    function automatic logic [fdb_pkg::PIX_W-1:0] random_level();
        case ($urandom_range(5))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return fdb_pkg::PIX_W'($urandom_range(255));
        endcase
    endfunction

    // One random frame: new settings, a full raster load with an occasional
    // broken start flag, sometimes loads past the end, then a burst of reads.
    task automatic run_frame();
        logic [fdb_pkg::DIM_W-1:0] w, h;
        int unsigned loads;
        logic first;
        settle();
        case ($urandom_range(15))
            0: begin
                w = '0;
                h = fdb_pkg::DIM_W'($urandom_range(0, 6));
            end
            1: begin
                w = fdb_pkg::DIM_W'($urandom_range(0, 8));
                h = '0;
            end
            default: begin
                w = fdb_pkg::DIM_W'($urandom_range(1, 8));
                h = fdb_pkg::DIM_W'($urandom_range(1, 6));
            end
        endcase
        set_config(1'($urandom_range(1)), random_level(), random_level(), w, h);
        loads = active_dim(w, MAX_W) * active_dim(h, MAX_H);
        for (int k = 0; k < loads; k++) begin
            first = (k == 0);
            if ($urandom_range(39) == 0) first = ~first;
            load_pixel(first, fdb_pkg::PIX_W'($urandom_range(255)));
        end
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 3))
                load_pixel(1'b0, fdb_pkg::PIX_W'($urandom_range(255)));
        repeat ($urandom_range(2, 8)) request_word(fdb_pkg::WIDX_W'($urandom_range(127)));
    endtask

    // Random frames under each idle pattern in turn.
    task automatic test_random_traffic();
        int unsigned send_pct [4] = '{0, 79, 0, 38};
        int unsigned recv_pct [4] = '{0, 0, 79, 38};
        int unsigned goal;
        for (int ph = 0; ph < 4; ph++) begin
            settle();
            send_idle_pct  = send_pct[ph];
            recv_stall_pct = recv_pct[ph];
            goal = kept_items + 30;
            while (kept_items < goal) run_frame();
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // ------------------------------------------------------------------------
    // Sequence.
    // ------------------------------------------------------------------------
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_tiny_frame();
        test_threshold_extremes();
        test_adaptive_saturation();
        test_dimension_clamp();
        test_width_shrink();
        test_frame_restart();
        test_output_backpressure();
        test_random_traffic();

        settle();
        if (mismatch_count == 0 && expected_words.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### files.f
hdl/fdb_pkg.sv
hdl/fdb_ram.sv
hdl/fdb_ctrl.sv
hdl/fdb_dpath.sv
hdl/frame_downscale_binarize.sv
dv/frame_downscale_binarize_tb.sv
